/* rtl/core/stl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// shared types and constants of the sine lfo tremolo
// ----------------------------------------------------------------------------
package stl_pkg;

  // channel count and lane order of one frame
  localparam int unsigned CHANNELS = 2;
  localparam int unsigned CH_LEFT  = 0;
  localparam int unsigned CH_RIGHT = 1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH      = 8'd1;

  localparam int unsigned PHASE_W = 32;
  localparam int unsigned STEP_W  = 31;
  localparam int unsigned DEPTH_W = 17;
  localparam int unsigned GAIN_W  = 17;
  localparam int unsigned MAG_W   = 15;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 31'd447392;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 17'd32768;
  localparam logic [DEPTH_W-1:0] FULL_DEPTH  = 17'd65536;
  localparam logic [MAG_W-1:0]   SINE_PEAK   = 15'd32767;

  // registered sine table read
  typedef struct packed {
    logic             neg;   // lower half of the cycle
    logic             peak;  // an odd quadrant at index zero
    logic [MAG_W-1:0] mag;   // table entry
  } stl_sine_t;

endpackage

/* rtl/core/sine_lfo_tremolo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_lfo_tremolo
// stereo tremolo: samples scaled by a sine lfo driven gain
// ----------------------------------------------------------------------------
// One stereo word in, one stereo word out. Each frame is scaled by
// gain = 1 - depth * (sin(phase) + 1) / 2 in q1.16, the product shifted right
// 16 bits rounding toward minus infinity; the 32-bit phase then advances by
// phase_step. The sine comes from a quarter-wave q1.15 table with no
// interpolation. On its way to the output register a frame passes the table
// read, registered at the accept edge, then the gain multiply (depth times
// lfo), then the per-channel multiplies. A word is taken only once the last
// result is placed; the output register lets the next word enter while the
// previous result waits, and stalls the pipe only when a finished result
// cannot be placed. Register 0 is phase_step (31 bits), register 1 is
// depth_fraction (17 bits, above 65536 counts as full depth); writes to
// other indexes are dropped. Write configuration only when idle.
// ----------------------------------------------------------------------------
module sine_lfo_tremolo
  import stl_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS     = 24,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  // input word
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] right_sample_i,
  // output word
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GAIN = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               out_valid_q, out_valid_d;

  logic in_acc;
  logic cfg_acc;
  logic load_out;

  stl_sine_t         sine;
  logic [GAIN_W-1:0] gain;

  logic signed [SAMPLE_BITS-1:0] samp_q   [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] lane_res [CHANNELS];

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  // the lanes write the output register once it is free or being drained
  assign load_out    = (state_q == ST_MUL) && (!out_valid_q || out_ready_i);

  // table read follows the live phase; the accept edge captures the frame's
  // sine since the phase only moves on that same edge
  stl_sine_rom #(
    .TBITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk_i   (clk_i),
    .phase_i (phase_q[PHASE_W-1 -: SINE_TABLE_BITS+2]),
    .sine_o  (sine)
  );

  // gain held until the lanes have taken it
  stl_gain u_gain (
    .clk_i   (clk_i),
    .en_i    (state_q == ST_GAIN),
    .sine_i  (sine),
    .depth_i (depth_q),
    .gain_o  (gain)
  );

  // one multiply lane per channel, results merged into the output word
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    stl_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (load_out),
      .sample_i (samp_q[c]),
      .gain_i   (gain),
      .result_o (lane_res[c])
    );
  end

  assign left_out_o  = lane_res[CH_LEFT];
  assign right_out_o = lane_res[CH_RIGHT];
  assign out_valid_o = out_valid_q;

  // input word capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      samp_q[CH_LEFT]  <= left_sample_i;
      samp_q[CH_RIGHT] <= right_sample_i;
    end
  end

  // sequencer, phase accumulator and output handshake
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          phase_d = phase_q + PHASE_W'(step_q);
          state_d = ST_GAIN;
        end
      end
      ST_GAIN: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // configuration registers, unknown indexes are dropped
  always_comb begin
    step_d  = step_q;
    depth_d = depth_q;
    if (cfg_acc) begin
      if (cfg_index_i == CFG_PHASE_STEP) begin
        step_d = cfg_data_i[STEP_W-1:0];
      end else if (cfg_index_i == CFG_DEPTH) begin
        depth_d = cfg_data_i[DEPTH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      step_q      <= STEP_RESET;
      depth_q     <= DEPTH_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/core/stl_sine_rom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_sine_rom
// quarter-wave sine table in q1.15 with quadrant folding and registered read
// ----------------------------------------------------------------------------
module stl_sine_rom
  import stl_pkg::*;
#(
  parameter int unsigned TBITS = 10
) (
  input  logic               clk_i,
  input  logic [TBITS+1:0]   phase_i,
  output stl_sine_t          sine_o
);

  localparam int unsigned N = 1 << TBITS;

  // 13th-order taylor series in q30, rounded to q15
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    x    = (64'd1686629713 * 64'(k)) >> TBITS;
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = 64'd0;
    term = ((term * x2) >> 30) / 64'd6;
    neg  = neg + term;
    term = ((term * x2) >> 30) / 64'd20;
    pos  = pos + term;
    term = ((term * x2) >> 30) / 64'd42;
    neg  = neg + term;
    term = ((term * x2) >> 30) / 64'd72;
    pos  = pos + term;
    term = ((term * x2) >> 30) / 64'd110;
    neg  = neg + term;
    term = ((term * x2) >> 30) / 64'd156;
    pos  = pos + term;
    if (neg >= pos) begin
      r = 64'd0;
    end else begin
      r = (pos - neg + 64'd16384) >> 15;
      if (r > 64'(SINE_PEAK)) begin
        r = 64'(SINE_PEAK);
      end
    end
    return r[MAG_W-1:0];
  endfunction

  function automatic logic [N*MAG_W-1:0] build_image();
    logic [N*MAG_W-1:0] img;
    img = '0;
    for (int unsigned k = 0; k < N; k++) begin
      img[k*MAG_W +: MAG_W] = quarter_sine(k);
    end
    return img;
  endfunction

  localparam logic [N*MAG_W-1:0] IMAGE = build_image();

  logic [1:0]       quad;
  logic [TBITS-1:0] idx;
  logic [TBITS-1:0] addr;
  stl_sine_t        sine_q;

  assign quad = phase_i[TBITS+1:TBITS];
  assign idx  = phase_i[TBITS-1:0];
  // mirrored index for the falling quadrants, wraps to zero at the peak
  assign addr = quad[0] ? (~idx + 1'b1) : idx;

  always_ff @(posedge clk_i) begin
    sine_q.neg  <= quad[1];
    sine_q.peak <= quad[0] && (idx == '0);
    sine_q.mag  <= IMAGE[addr*MAG_W +: MAG_W];
  end

  assign sine_o = sine_q;

endmodule

/* rtl/core/stl_gain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_gain
// lfo value and tremolo gain in q1.16 from the sine read
// ----------------------------------------------------------------------------
module stl_gain
  import stl_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  stl_sine_t          sine_i,
  input  logic [DEPTH_W-1:0] depth_i,
  output logic [GAIN_W-1:0]  gain_o
);

  logic [MAG_W-1:0]   mag;
  logic [15:0]        lfo;
  logic [DEPTH_W-1:0] depth_sat;
  logic [32:0]        prod;
  logic [16:0]        d;
  logic [GAIN_W-1:0]  gain_d;
  logic [GAIN_W-1:0]  gain_q;

  assign mag       = sine_i.peak ? SINE_PEAK : sine_i.mag;
  // (sin + 1) / 2, always inside 1..65535
  assign lfo       = sine_i.neg ? (16'h8000 - 16'(mag)) : (16'h8000 + 16'(mag));
  assign depth_sat = (depth_i > FULL_DEPTH) ? FULL_DEPTH : depth_i;
  assign prod      = 33'(depth_sat) * 33'(lfo) + 33'd32768;
  assign d         = prod[32:16];
  assign gain_d    = FULL_DEPTH - d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gain_q <= gain_d;
    end
  end

  assign gain_o = gain_q;

endmodule

/* rtl/core/stl_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_lane
// one channel: sample times gain, floor shift by 16, registered result
// ----------------------------------------------------------------------------
module stl_lane
  import stl_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic        [GAIN_W-1:0]      gain_i,
  output logic signed [SAMPLE_BITS-1:0] result_o
);

  localparam int unsigned PROD_W = SAMPLE_BITS + GAIN_W + 1;

  logic signed [PROD_W-1:0]      prod;
  logic signed [SAMPLE_BITS-1:0] res_q;

  // gain <= 1.0, so the shifted product always fits the sample width
  assign prod = PROD_W'(sample_i) * $signed({1'b0, gain_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= prod[SAMPLE_BITS+15:16];
    end
  end

  assign result_o = res_q;

endmodule

/* rtl/core/stl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_checker
// port-level checks of the tremolo, bound to the top level
// ----------------------------------------------------------------------------
module stl_checker
  import stl_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input logic signed [SAMPLE_BITS-1:0] right_sample_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] left_out_o,
  input logic signed [SAMPLE_BITS-1:0] right_out_o
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  // one word in flight: no second accept right after the first
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input accepted while a word is in flight");

  // no result rises directly after an accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // the configuration port never stalls
  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

  // a waiting input word holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=>
      (in_valid_i && $stable(left_sample_i) && $stable(right_sample_i)))
    else $error("waiting input word changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(left_out_o) && $stable(right_out_o)))
    else $error("stalled output word changed");

endmodule

bind sine_lfo_tremolo stl_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_stl_checker (.*);
